[src/sti_pkg.sv]
// Shared types and constants for the sorted table insert/search block.
// No dependencies; used by sorted_table_insert_search.
package sti_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int VALUE_W   = 32;
  localparam int STATUS_W  = 2;
  localparam int POS_W     = 7;
  localparam int ENTRIES_W = 8;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 16;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT,
    S_SRCH_CHK,
    S_SRCH_CMP,
    S_DONE
  } state_t;

endpackage

[src/sorted_table_insert_search.sv]
// Sorted table of signed 32-bit values with ordered insert and binary search.
// Depends on sti_pkg for state type, status codes and field widths.
//
// The block holds up to DEPTH signed values in ascending order in a memory with
// one write port and one registered read port, and takes one command at a time.
// An insert moves the larger entries up and stops at a smaller or equal entry,
// or once it has moved every held entry up. The larger entries move up one a
// cycle through the memory read port. An insert into an empty table goes straight
// to the write, and one into a full table is refused. A search makes one probe
// per step of a binary search and ends when the value is found or the range is
// empty. The finished result sits in an output register, so the next command is
// taken while it waits on out_tready.
module sorted_table_insert_search #(
  parameter int DEPTH = sti_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sti_pkg::IN_DATA_W-1:0]   in_tdata,   // [31:0] value
  input  logic                            in_tuser,   // [0] cmd
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sti_pkg::OUT_DATA_W-1:0]  out_tdata,  // [6:0] position, [14:7] entries
  output logic [sti_pkg::STATUS_W-1:0]    out_tuser   // [1:0] status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Table storage
  logic signed [sti_pkg::VALUE_W-1:0] mem [DEPTH];
  logic signed [sti_pkg::VALUE_W-1:0] rd_data_r;
  logic [IW-1:0]                      rd_addr;
  logic                               wr_en;
  logic [IW-1:0]                      wr_addr;
  logic signed [sti_pkg::VALUE_W-1:0] wr_data;

  sti_pkg::state_t state_r, state_nxt;

  logic signed [sti_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  slot_r, slot_nxt;
  logic [CW-1:0]  lo_r, lo_nxt;
  logic [CW-1:0]  hi_r, hi_nxt;     // exclusive upper bound
  logic [CW-1:0]  mid_r, mid_nxt;
  sti_pkg::status_t res_status_r, res_status_nxt;
  logic [CW-1:0]  res_pos_r, res_pos_nxt;

  logic                          out_valid_r, out_valid_nxt;
  sti_pkg::status_t              out_status_r, out_status_nxt;
  logic [sti_pkg::POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [sti_pkg::ENTRIES_W-1:0] out_entries_r, out_entries_nxt;

  logic                 accept;
  logic                 out_free;
  logic                 shift_more;
  logic [CW:0]          mid_sum;
  logic [CW-1:0]        mid_c;
  logic [CW-1:0]        slot_m1;
  logic [CW-1:0]        slot_m2;
  logic [CW+sti_pkg::POS_W-1:0]     pos_ext;
  logic [CW+sti_pkg::ENTRIES_W-1:0] cnt_ext;

  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign shift_more = rd_data_r > val_r;
  assign slot_m1    = slot_r - CW'(1);
  assign slot_m2    = slot_r - CW'(2);
  // Midpoint of the inclusive range [lo, hi-1]
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r} - (CW+1)'(1);
  assign mid_c      = mid_sum[CW:1];
  assign pos_ext    = {{sti_pkg::POS_W{1'b0}}, res_pos_r};
  assign cnt_ext    = {{sti_pkg::ENTRIES_W{1'b0}}, count_r};

  // Next state and datapath
  always_comb begin
    state_nxt       = state_r;
    val_nxt         = val_r;
    count_nxt       = count_r;
    slot_nxt        = slot_r;
    lo_nxt          = lo_r;
    hi_nxt          = hi_r;
    mid_nxt         = mid_r;
    res_status_nxt  = res_status_r;
    res_pos_nxt     = res_pos_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_status_nxt  = out_status_r;
    out_pos_nxt     = out_pos_r;
    out_entries_nxt = out_entries_r;
    case (state_r)
      sti_pkg::S_IDLE: begin
        if (accept) begin
          val_nxt = in_tdata;
          if (in_tuser == sti_pkg::CMD_SEARCH) begin
            lo_nxt    = '0;
            hi_nxt    = count_r;
            state_nxt = sti_pkg::S_SRCH_CHK;
          end else if (count_r == CW'(DEPTH)) begin
            res_status_nxt = sti_pkg::ST_FULL;
            res_pos_nxt    = '0;
            state_nxt      = sti_pkg::S_DONE;
          end else begin
            slot_nxt  = count_r;
            state_nxt = (count_r == '0) ? sti_pkg::S_INS_PUT : sti_pkg::S_INS_RD;
          end
        end
      end
      sti_pkg::S_INS_RD: begin
        state_nxt = sti_pkg::S_INS_CMP;
      end
      sti_pkg::S_INS_CMP: begin
        // Move the larger neighbour up; stop at the first one not greater or at slot 0
        if (shift_more) begin
          slot_nxt = slot_m1;
          if (slot_r == CW'(1)) begin
            state_nxt = sti_pkg::S_INS_PUT;
          end
        end else begin
          state_nxt = sti_pkg::S_INS_PUT;
        end
      end
      sti_pkg::S_INS_PUT: begin
        count_nxt      = count_r + CW'(1);
        res_status_nxt = sti_pkg::ST_OK;
        res_pos_nxt    = slot_r;
        state_nxt      = sti_pkg::S_DONE;
      end
      sti_pkg::S_SRCH_CHK: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_c;
          state_nxt = sti_pkg::S_SRCH_CMP;
        end else begin
          res_status_nxt = sti_pkg::ST_NOT_FOUND;
          res_pos_nxt    = '0;
          state_nxt      = sti_pkg::S_DONE;
        end
      end
      sti_pkg::S_SRCH_CMP: begin
        if (val_r > rd_data_r) begin
          lo_nxt    = mid_r + CW'(1);
          state_nxt = sti_pkg::S_SRCH_CHK;
        end else if (val_r < rd_data_r) begin
          hi_nxt    = mid_r;
          state_nxt = sti_pkg::S_SRCH_CHK;
        end else begin
          res_status_nxt = sti_pkg::ST_OK;
          res_pos_nxt    = mid_r;
          state_nxt      = sti_pkg::S_DONE;
        end
      end
      sti_pkg::S_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = res_status_r;
          out_pos_nxt     = pos_ext[sti_pkg::POS_W-1:0];
          out_entries_nxt = cnt_ext[sti_pkg::ENTRIES_W-1:0];
          state_nxt       = sti_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sti_pkg::S_IDLE;
      end
    endcase
  end

  // Handshake and memory port controls
  always_comb begin
    in_tready = 1'b0;
    rd_addr   = slot_m1[IW-1:0];
    wr_en     = 1'b0;
    wr_addr   = slot_r[IW-1:0];
    wr_data   = val_r;
    case (state_r)
      sti_pkg::S_IDLE: begin
        in_tready = 1'b1;
      end
      sti_pkg::S_INS_RD: begin
        rd_addr = slot_m1[IW-1:0];
      end
      sti_pkg::S_INS_CMP: begin
        rd_addr = slot_m2[IW-1:0];
        if (shift_more) begin
          wr_en   = 1'b1;
          wr_data = rd_data_r;
        end
      end
      sti_pkg::S_INS_PUT: begin
        wr_en = 1'b1;
      end
      sti_pkg::S_SRCH_CHK: begin
        rd_addr = mid_c[IW-1:0];
      end
      sti_pkg::S_SRCH_CMP: begin
        rd_addr = mid_r[IW-1:0];
      end
      sti_pkg::S_DONE: begin
        rd_addr = slot_m1[IW-1:0];
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sti_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r         <= val_nxt;
    slot_r        <= slot_nxt;
    lo_r          <= lo_nxt;
    hi_r          <= hi_nxt;
    mid_r         <= mid_nxt;
    res_status_r  <= res_status_nxt;
    res_pos_r     <= res_pos_nxt;
    out_status_r  <= out_status_nxt;
    out_pos_r     <= out_pos_nxt;
    out_entries_r <= out_entries_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {1'b0, out_entries_r, out_pos_r};

endmodule

[dv/tb_sorted_table_insert_search.sv]
// Self-checking testbench for sorted_table_insert_search: directed and random
// insert/search items against a cycle-free table predictor, with random stalls.
// Depends on sti_pkg and on the sorted_table_insert_search RTL.
module tb_sorted_table_insert_search;

  localparam int TBL_DEPTH  = sti_pkg::DEPTH_DEF;
  localparam int RAND_ITEMS = 1500;
  localparam int TAIL_ITEMS = 150;   // no idling on either side this close to the end
  localparam int DRAIN_CYC  = 200;   // longest insert moves every held entry up

  typedef struct {
    logic                        cmd;
    logic [sti_pkg::VALUE_W-1:0] value;
  } cmd_item_t;

  typedef struct {
    sti_pkg::status_t              status;
    logic [sti_pkg::POS_W-1:0]     pos;
    logic [sti_pkg::ENTRIES_W-1:0] entries;
  } tbl_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [sti_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // [31:0] value
  logic                           in_tuser = 1'b0; // [0] cmd
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [sti_pkg::OUT_DATA_W-1:0] out_tdata;       // [6:0] position, [14:7] entries
  logic [sti_pkg::STATUS_W-1:0]   out_tuser;       // [1:0] status

  sorted_table_insert_search dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a shadow of the sorted store and its entry count.
  logic signed [sti_pkg::VALUE_W-1:0] tbl_vals [TBL_DEPTH];
  int                                 tbl_count = 0;

  cmd_item_t   cmd_queue[$];
  tbl_result_t pending_results[$];
  int          total_items = 0;
  int          items_taken = 0;
  int          err_count = 0;
  int          n_ins_ok = 0, n_full = 0, n_found = 0, n_missing = 0;
  logic        in_acc = 1'b0;
  int          in_gap = 0, in_calm = 0;
  int          out_gap = 0, out_calm = 0;

  task automatic flag_mismatch(string msg);
    err_count++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Apply one command to the shadow table and return the result it causes.
  function automatic tbl_result_t table_predict(
    logic                               cmd,
    logic signed [sti_pkg::VALUE_W-1:0] v
  );
    tbl_result_t r;
    int slot, lo, hi, mid;
    r.status = sti_pkg::ST_NOT_FOUND;
    r.pos    = '0;
    if (cmd == sti_pkg::CMD_INSERT) begin
      if (tbl_count >= TBL_DEPTH) begin
        r.status = sti_pkg::ST_FULL;
      end else begin
        slot = tbl_count;
        // shift larger entries up; equal ones stay below the new value
        while (slot > 0) begin
          if (tbl_vals[slot-1] <= v) break;
          tbl_vals[slot] = tbl_vals[slot-1];
          slot--;
        end
        tbl_vals[slot] = v;
        tbl_count++;
        r.status = sti_pkg::ST_OK;
        r.pos    = slot[sti_pkg::POS_W-1:0];
      end
    end else begin
      lo = 0;
      hi = tbl_count - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (v > tbl_vals[mid]) begin
          lo = mid + 1;
        end else if (v < tbl_vals[mid]) begin
          hi = mid - 1;
        end else begin
          r.status = sti_pkg::ST_OK;
          r.pos    = mid[sti_pkg::POS_W-1:0];
          break;
        end
      end
    end
    r.entries = tbl_count[sti_pkg::ENTRIES_W-1:0];
    return r;
  endfunction

  // Stimulus: directed items, then random ones shaped by a rough view of the table.
  initial begin
    int          gen_count;
    int          sel, k;
    logic [31:0] v;
    logic [31:0] gen_vals[$];
    logic [31:0] directed_vals[$];
    logic        directed_cmds[$];
    cmd_item_t   it;

    // empty-table search, extremes, equal values, present and absent searches
    directed_cmds = '{sti_pkg::CMD_SEARCH, sti_pkg::CMD_INSERT, sti_pkg::CMD_INSERT,
                      sti_pkg::CMD_INSERT, sti_pkg::CMD_INSERT, sti_pkg::CMD_INSERT,
                      sti_pkg::CMD_INSERT, sti_pkg::CMD_INSERT, sti_pkg::CMD_INSERT,
                      sti_pkg::CMD_SEARCH, sti_pkg::CMD_SEARCH, sti_pkg::CMD_SEARCH,
                      sti_pkg::CMD_SEARCH, sti_pkg::CMD_SEARCH, sti_pkg::CMD_SEARCH,
                      sti_pkg::CMD_SEARCH, sti_pkg::CMD_SEARCH, sti_pkg::CMD_INSERT,
                      sti_pkg::CMD_INSERT, sti_pkg::CMD_SEARCH, sti_pkg::CMD_SEARCH};
    directed_vals = '{32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                      32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002, 32'h8000_0001,
                      32'h7FFF_FFFE, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                      32'hAAAA_AAAA};
    gen_count = 0;
    foreach (directed_cmds[i]) begin
      it.cmd   = directed_cmds[i];
      it.value = directed_vals[i];
      cmd_queue.push_back(it);
      if (it.cmd == sti_pkg::CMD_INSERT) begin
        gen_vals.push_back(it.value);
        gen_count++;
      end
    end

    // The table fills part way through; later inserts hit the full case.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      sel = $urandom_range(0, 99);
      it.cmd = (sel < ((gen_count < TBL_DEPTH) ? 45 : 20)) ? sti_pkg::CMD_INSERT
                                                           : sti_pkg::CMD_SEARCH;
      sel = $urandom_range(0, 9);
      if (it.cmd == sti_pkg::CMD_SEARCH && gen_vals.size() > 0 && sel < 6) begin
        v = gen_vals[$urandom_range(0, gen_vals.size() - 1)];
      end else if (it.cmd == sti_pkg::CMD_SEARCH && gen_vals.size() > 0 && sel < 8) begin
        // neighbour of a held value, usually absent
        v = gen_vals[$urandom_range(0, gen_vals.size() - 1)];
        v = $urandom_range(0, 1) ? v + 32'd1 : v - 32'd1;
      end else begin
        k = $urandom_range(0, 9);
        if (k < 4)
          v = 32'(int'($urandom_range(0, 16)) - 8);
        else if (k == 4)
          v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                   : 32'h7FFF_FFFF - $urandom_range(0, 3);
        else
          v = $urandom;
      end
      it.value = v;
      cmd_queue.push_back(it);
      if (it.cmd == sti_pkg::CMD_INSERT && gen_count < TBL_DEPTH) begin
        gen_vals.push_back(v);
        gen_count++;
      end
    end
    total_items = cmd_queue.size();
  end

  // Reset once, then wait for every item to be taken and every result to arrive.
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (total_items == 0 || items_taken < total_items) @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
    if (pending_results.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("Covered %0d items: %0d inserts placed, %0d refused on a full table,",
             items_taken, n_ins_ok, n_full);
    $display("%0d searches found, %0d not found; %0d mismatches.",
             n_found, n_missing, err_count);
    if (err_count == 0)
      $display("sorted_table_insert_search test passed");
    else
      $display("sorted_table_insert_search test failed");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("Timeout: %0d of %0d items taken, %0d results outstanding",
             items_taken, total_items, pending_results.size());
    $display("sorted_table_insert_search test failed");
    $finish;
  end

  // Command driver: advance on an accepted item, idle in random bursts.
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= cmd_queue[0].value;
        in_tuser  <= cmd_queue[0].cmd;
        void'(cmd_queue.pop_front());
        if (in_calm > 0)
          in_calm--;
        else if ($urandom_range(0, 29) == 0)
          in_calm = $urandom_range(20, 60);
        else if (cmd_queue.size() > TAIL_ITEMS && $urandom_range(0, 4) == 0)
          in_gap = $urandom_range(1, 19);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result side back-pressure, independent of out_tvalid so stalls hit every phase.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_calm > 0)
          out_calm--;
        else if ($urandom_range(0, 199) == 0)
          out_calm = $urandom_range(100, 400);
        else if (cmd_queue.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0)
          out_gap = $urandom_range(1, 19);
      end
    end
  end

  // Monitor: predict on each accepted command, check each accepted result.
  always @(posedge clk) begin
    tbl_result_t                    want;
    logic [sti_pkg::OUT_DATA_W-1:0] want_data;
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        pending_results.push_back(table_predict(in_tuser, in_tdata));
        items_taken++;
      end
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result status=%0d data=%h",
                                  out_tuser, out_tdata));
        end else begin
          want = pending_results.pop_front();
          want_data = '0;
          want_data[sti_pkg::POS_W-1:0] = want.pos;
          want_data[sti_pkg::POS_W+sti_pkg::ENTRIES_W-1:sti_pkg::POS_W] = want.entries;
          if (out_tuser !== want.status || out_tdata !== want_data)
            flag_mismatch($sformatf(
              "status %0d pos %0d entries %0d, want %0d %0d %0d (pad %b)",
              out_tuser, out_tdata[sti_pkg::POS_W-1:0],
              out_tdata[sti_pkg::POS_W+sti_pkg::ENTRIES_W-1:sti_pkg::POS_W],
              want.status, want.pos, want.entries,
              out_tdata[sti_pkg::OUT_DATA_W-1]));
          case (want.status)
            sti_pkg::ST_FULL:      n_full++;
            sti_pkg::ST_NOT_FOUND: n_missing++;
            default: ;
          endcase
        end
      end
    end
  end

  // Split OK results into placed inserts and found searches by watching the count.
  int prev_entries = 0;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready && out_tuser === sti_pkg::ST_OK) begin
      if (int'(out_tdata[sti_pkg::POS_W+sti_pkg::ENTRIES_W-1:sti_pkg::POS_W])
          != prev_entries)
        n_ins_ok++;
      else
        n_found++;
    end
    if (rst_n && out_tvalid && out_tready)
      prev_entries <= int'(out_tdata[sti_pkg::POS_W+sti_pkg::ENTRIES_W-1:sti_pkg::POS_W]);
  end

endmodule

[files.f]
src/sti_pkg.sv
src/sorted_table_insert_search.sv
dv/tb_sorted_table_insert_search.sv
